// ===== rtl/dwm_pkg.sv =====
// Package for the decimal word machine.
// Holds character, action, status, opcode and state definitions; no dependencies.
package dwm_pkg;

    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_G     = 8'h47;
    localparam logic [7:0]  CH_D     = 8'h44;
    localparam logic [7:0]  CH_P     = 8'h50;
    localparam logic [7:0]  CH_H     = 8'h48;
    localparam logic [7:0]  CH_L     = 8'h4C;
    localparam logic [7:0]  CH_R     = 8'h52;
    localparam logic [7:0]  CH_S     = 8'h53;
    localparam logic [7:0]  CH_C     = 8'h43;
    localparam logic [7:0]  CH_B     = 8'h42;
    localparam logic [7:0]  CH_T     = 8'h54;
    localparam logic [31:0] SPACES   = {4{CH_SPACE}};
    localparam logic [6:0]  TEN      = 7'd10;

    localparam logic [1:0] ACT_NEW   = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_READ_REQ = 3'd1,
        ST_PAGE     = 3'd2,
        ST_HALTED   = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_BAD_ADDR = 3'd5,
        ST_NOT_RUN  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        OP_UNKNOWN,
        OP_GD,
        OP_PD,
        OP_HALT,
        OP_LR,
        OP_SR,
        OP_CR,
        OP_BT
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_OPERAND,
        S_PAGE_RD,
        S_PAGE_CAP,
        S_EMIT
    } state_t;

    function automatic op_t decode_op(input logic [7:0] c0, input logic [7:0] c1);
        op_t op;
        if (c0 == CH_G && c1 == CH_D)      op = OP_GD;
        else if (c0 == CH_P && c1 == CH_D) op = OP_PD;
        else if (c0 == CH_H)               op = OP_HALT;
        else if (c0 == CH_L && c1 == CH_R) op = OP_LR;
        else if (c0 == CH_S && c1 == CH_R) op = OP_SR;
        else if (c0 == CH_C && c1 == CH_R) op = OP_CR;
        else if (c0 == CH_B && c1 == CH_T) op = OP_BT;
        else                               op = OP_UNKNOWN;
        return op;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/decimal_word_machine_cpu_top.sv =====
// Top level of the decimal word machine: sequencer, registers and word memory.
// Depends on dwm_pkg and dwm_ram.
//
// Input channel s_*: s_tuser carries the action (new job, write word, step).
// A new-job or write transaction gives no result.
// A step gives one result on m_*: fetch, then decode and emit for most
// instructions, with an operand read before emit for LR and CR; PD gives
// one result per page word (page read, capture, emit), each word held in the
// sequencer until the output register is free. The registered read of the
// word memory sets these steps; no new transaction is taken until a step ends.
// The output register holds a result until m_tready; while it is full and
// m_tready is low the sequencer waits before loading the next result.
// Reset (and a new job) marks every word invalid so that it reads as four
// spaces; registers return to spaces/zero and the machine is stopped until
// a new-job transaction.
// m_tlast marks the final result of a step; m_tuser carries the status.
module decimal_word_machine_cpu_top #(
    parameter int MEM_WORDS  = 100,
    parameter int PAGE_WORDS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[6:0], word[38:7], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // data_word[31:0], operand_address[38:32],
                                   // counter[45:39], compare_flag[46], zero fill
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    localparam int         AW      = $clog2(MEM_WORDS);
    localparam int         CW      = $clog2(PAGE_WORDS + 1);
    localparam logic [6:0] MEM_LIM = 7'(MEM_WORDS);
    localparam logic [7:0] MEM_LIM8 = 8'(MEM_WORDS);
    localparam logic [7:0] PAGE8   = 8'(PAGE_WORDS);
    localparam logic [CW-1:0] PAGE_LAST = CW'(PAGE_WORDS - 1);

    dwm_pkg::state_t  state_reg, state_next;
    logic             running_reg, running_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      instr_reg, instr_next;
    logic [6:0]       pc_reg, pc_next;
    logic             eq_reg, eq_next;
    logic [MEM_WORDS-1:0] valid_reg, valid_next;
    logic             rd_valid_reg;
    dwm_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      res_data_reg, res_data_next;
    logic [6:0]       res_oaddr_reg, res_oaddr_next;
    logic             res_last_reg, res_last_next;
    logic [6:0]       page_base_reg, page_base_next;
    logic [CW-1:0]    page_cnt_reg, page_cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [47:0]      m_tdata_reg, m_tdata_next;
    dwm_pkg::status_t m_tuser_reg, m_tuser_next;
    logic             m_tlast_reg, m_tlast_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;
    logic [31:0]      rdata_eff;

    logic [1:0]       in_action;
    logic [6:0]       in_addr;
    logic [31:0]      in_word;
    logic [7:0]       c0, c1, c2, c3, d2, d3;
    logic [6:0]       op_addr;
    logic             digits_ok;
    dwm_pkg::op_t     op;
    logic [6:0]       page_addr;

    assign in_action = s_tuser;
    assign in_addr   = s_tdata[6:0];
    assign in_word   = s_tdata[38:7];

    assign c0 = instr_reg[31:24];
    assign c1 = instr_reg[23:16];
    assign c2 = instr_reg[15:8];
    assign c3 = instr_reg[7:0];
    assign d2 = c2 - dwm_pkg::CH_ZERO;
    assign d3 = c3 - dwm_pkg::CH_ZERO;
    assign op_addr   = {3'b000, d2[3:0]} * dwm_pkg::TEN + {3'b000, d3[3:0]};
    assign digits_ok = dwm_pkg::is_digit(c2) && dwm_pkg::is_digit(c3);
    assign op        = dwm_pkg::decode_op(c0, c1);
    assign page_addr = page_base_reg + 7'(page_cnt_reg);
    assign rdata_eff = rd_valid_reg ? ram_rdata : dwm_pkg::SPACES;

    assign s_tready = (state_reg == dwm_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    dwm_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dwm_pkg::S_IDLE;
            running_reg  <= 1'b0;
            acc_reg      <= dwm_pkg::SPACES;
            instr_reg    <= dwm_pkg::SPACES;
            pc_reg       <= '0;
            eq_reg       <= 1'b0;
            valid_reg    <= '0;
            page_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            acc_reg      <= acc_next;
            instr_reg    <= instr_next;
            pc_reg       <= pc_next;
            eq_reg       <= eq_next;
            valid_reg    <= valid_next;
            page_cnt_reg <= page_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg   <= valid_reg[ram_raddr];
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_oaddr_reg  <= res_oaddr_next;
        res_last_reg   <= res_last_next;
        page_base_reg  <= page_base_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        acc_next        = acc_reg;
        instr_next      = instr_reg;
        pc_next         = pc_reg;
        eq_next         = eq_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_oaddr_next  = res_oaddr_reg;
        res_last_next   = res_last_reg;
        page_base_next  = page_base_reg;
        page_cnt_next   = page_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        ram_we          = 1'b0;
        ram_waddr       = in_addr[AW-1:0];
        ram_wdata       = in_word;
        ram_raddr       = pc_reg[AW-1:0];

        case (state_reg)
            dwm_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_action)
                        dwm_pkg::ACT_NEW:
                        begin
                            valid_next   = '0;
                            acc_next     = dwm_pkg::SPACES;
                            instr_next   = dwm_pkg::SPACES;
                            pc_next      = '0;
                            eq_next      = 1'b0;
                            running_next = 1'b1;
                        end
                        dwm_pkg::ACT_WRITE:
                        begin
                            if (in_addr < MEM_LIM)
                            begin
                                ram_we = 1'b1;
                                valid_next[in_addr[AW-1:0]] = 1'b1;
                            end
                        end
                        dwm_pkg::ACT_STEP:
                        begin
                            res_data_next  = acc_reg;
                            res_oaddr_next = '0;
                            res_last_next  = 1'b1;
                            if (!running_reg)
                            begin
                                res_status_next = dwm_pkg::ST_NOT_RUN;
                                state_next      = dwm_pkg::S_EMIT;
                            end
                            else if (pc_reg >= MEM_LIM)
                            begin
                                running_next    = 1'b0;
                                res_status_next = dwm_pkg::ST_BAD_ADDR;
                                state_next      = dwm_pkg::S_EMIT;
                            end
                            else
                            begin
                                state_next = dwm_pkg::S_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            dwm_pkg::S_FETCH:
            begin
                instr_next = rdata_eff;
                pc_next    = pc_reg + 7'd1;
                state_next = dwm_pkg::S_DECODE;
            end

            dwm_pkg::S_DECODE:
            begin
                ram_raddr       = op_addr[AW-1:0];
                ram_waddr       = op_addr[AW-1:0];
                ram_wdata       = acc_reg;
                res_data_next   = acc_reg;
                res_oaddr_next  = '0;
                res_last_next   = 1'b1;
                res_status_next = dwm_pkg::ST_DONE;
                state_next      = dwm_pkg::S_EMIT;
                if (op == dwm_pkg::OP_UNKNOWN)
                begin
                    res_status_next = dwm_pkg::ST_UNKNOWN;
                end
                else if (op == dwm_pkg::OP_HALT)
                begin
                    running_next    = 1'b0;
                    res_status_next = dwm_pkg::ST_HALTED;
                end
                else if (!digits_ok || op_addr >= MEM_LIM ||
                         (op == dwm_pkg::OP_PD &&
                          ({1'b0, op_addr} + PAGE8) > MEM_LIM8))
                begin
                    running_next    = 1'b0;
                    res_status_next = dwm_pkg::ST_BAD_ADDR;
                end
                else
                begin
                    res_oaddr_next = op_addr;
                    case (op)
                        dwm_pkg::OP_GD:
                        begin
                            res_status_next = dwm_pkg::ST_READ_REQ;
                        end
                        dwm_pkg::OP_PD:
                        begin
                            page_base_next = op_addr;
                            page_cnt_next  = '0;
                            state_next     = dwm_pkg::S_PAGE_RD;
                        end
                        dwm_pkg::OP_LR, dwm_pkg::OP_CR:
                        begin
                            state_next = dwm_pkg::S_OPERAND;
                        end
                        dwm_pkg::OP_SR:
                        begin
                            ram_we = 1'b1;
                            valid_next[op_addr[AW-1:0]] = 1'b1;
                        end
                        dwm_pkg::OP_BT:
                        begin
                            if (eq_reg)
                            begin
                                pc_next = op_addr;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            dwm_pkg::S_OPERAND:
            begin
                if (op == dwm_pkg::OP_LR)
                begin
                    acc_next      = rdata_eff;
                    res_data_next = rdata_eff;
                end
                else
                begin
                    eq_next = (acc_reg == rdata_eff);
                end
                state_next = dwm_pkg::S_EMIT;
            end

            dwm_pkg::S_PAGE_RD:
            begin
                ram_raddr  = page_addr[AW-1:0];
                state_next = dwm_pkg::S_PAGE_CAP;
            end

            dwm_pkg::S_PAGE_CAP:
            begin
                res_status_next = dwm_pkg::ST_PAGE;
                res_data_next   = rdata_eff;
                res_oaddr_next  = page_addr;
                res_last_next   = (page_cnt_reg == PAGE_LAST);
                state_next      = dwm_pkg::S_EMIT;
            end

            dwm_pkg::S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, eq_reg, pc_reg, res_oaddr_reg, res_data_reg};
                    m_tuser_next  = res_status_reg;
                    m_tlast_next  = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = dwm_pkg::S_IDLE;
                    end
                    else
                    begin
                        page_cnt_next = page_cnt_reg + CW'(1);
                        state_next    = dwm_pkg::S_PAGE_RD;
                    end
                end
            end

            default:
            begin
                state_next = dwm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dwm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dwm_chk.sv =====
// Port-level checker for the decimal word machine, bound to the top level.
// Depends on dwm_pkg and decimal_word_machine_cpu_top.
module dwm_chk #(
    parameter int MEM_WORDS = 100
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    localparam logic [6:0] MEM_LIM = 7'(MEM_WORDS);

    // stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result changed while stalled");

    // only page words may be non-final
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != dwm_pkg::ST_PAGE |-> m_tlast)
        else $error("non-page result without tlast");

    a_oaddr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[38:32] < MEM_LIM && m_tdata[45:39] <= MEM_LIM)
        else $error("address or counter out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dwm_pkg::ST_BAD_ADDR || m_tuser == dwm_pkg::ST_NOT_RUN ||
                     m_tuser == dwm_pkg::ST_HALTED || m_tuser == dwm_pkg::ST_UNKNOWN)
        |-> m_tdata[38:32] == 7'd0)
        else $error("error result with non-zero operand address");

endmodule

bind decimal_word_machine_cpu_top dwm_chk #(.MEM_WORDS(MEM_WORDS)) u_dwm_chk (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for decimal_word_machine_cpu_top: a scoreboard class keeps its own
// machine state, predicts every result of each accepted transaction and checks the stream.
// Depends on dwm_pkg and the RTL of the block.
module tb_top;
    import dwm_pkg::*;

    localparam int MEM_WORDS  = 100;
    localparam int PAGE_WORDS = 10;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] data_word;
        logic [6:0]  oper_addr;
        logic [6:0]  counter;
        logic        flag;
        logic        last;
    } machine_result_t;

    class machine_scoreboard;
        logic [31:0]     mem [MEM_WORDS];
        logic [31:0]     acc;
        logic [31:0]     instr;
        logic [6:0]      pc;
        logic            eq_flag;
        logic            running;
        machine_result_t due_results[$];
        int              errors;
        int              n_steps;
        int              n_results;
        int              n_pages;

        function new();
            clear_machine();
            running = 1'b0;
        endfunction

        function void clear_machine();
            foreach (mem[i])
                mem[i] = SPACES;
            acc     = SPACES;
            instr   = SPACES;
            pc      = '0;
            eq_flag = 1'b0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void add_result(status_t st, logic [31:0] dw, logic [6:0] oa, logic lst);
            machine_result_t r;
            r.status    = st;
            r.data_word = dw;
            r.oper_addr = oa;
            r.counter   = pc;
            r.flag      = eq_flag;
            r.last      = lst;
            due_results.push_back(r);
        endfunction

        function void stop_bad();
            running = 1'b0;
            add_result(ST_BAD_ADDR, acc, '0, 1'b1);
        endfunction

        function op_t classify(logic [7:0] c0, logic [7:0] c1);
            if (c0 == CH_H)
                return OP_HALT;
            case ({c0, c1})
                {CH_G, CH_D}: return OP_GD;
                {CH_P, CH_D}: return OP_PD;
                {CH_L, CH_R}: return OP_LR;
                {CH_S, CH_R}: return OP_SR;
                {CH_C, CH_R}: return OP_CR;
                {CH_B, CH_T}: return OP_BT;
                default:      return OP_UNKNOWN;
            endcase
        endfunction

        function logic digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void note_input(logic [1:0] act, logic [6:0] adr, logic [31:0] wd);
            logic [7:0] c0, c1, c2, c3;
            op_t        op;
            int         oper;
            case (act)
                ACT_NEW:
                begin
                    clear_machine();
                    running = 1'b1;
                end
                ACT_WRITE:
                begin
                    if (adr < MEM_WORDS)
                        mem[adr] = wd;
                end
                ACT_STEP:
                begin
                    n_steps++;
                    if (!running)
                        add_result(ST_NOT_RUN, acc, '0, 1'b1);
                    else if (pc >= MEM_WORDS)
                        stop_bad();
                    else
                    begin
                        instr = mem[pc];
                        pc++;
                        {c0, c1, c2, c3} = instr;
                        op = classify(c0, c1);
                        if (op == OP_UNKNOWN)
                            add_result(ST_UNKNOWN, acc, '0, 1'b1);
                        else if (op == OP_HALT)
                        begin
                            running = 1'b0;
                            add_result(ST_HALTED, acc, '0, 1'b1);
                        end
                        else if (!digit(c2) || !digit(c3))
                            stop_bad();
                        else
                        begin
                            oper = (int'(c2) - int'(CH_ZERO)) * 10 + (int'(c3) - int'(CH_ZERO));
                            if (oper >= MEM_WORDS)
                                stop_bad();
                            else if (op == OP_PD)
                            begin
                                if (oper + PAGE_WORDS > MEM_WORDS)
                                    stop_bad();
                                else
                                    for (int i = 0; i < PAGE_WORDS; i++)
                                        add_result(ST_PAGE, mem[oper + i], 7'(oper + i),
                                                   i == PAGE_WORDS - 1);
                            end
                            else
                            begin
                                case (op)
                                    OP_LR: acc = mem[oper];
                                    OP_SR: mem[oper] = acc;
                                    OP_CR: eq_flag = (acc == mem[oper]);
                                    OP_BT: if (eq_flag) pc = 7'(oper);
                                    default: ;
                                endcase
                                add_result(op == OP_GD ? ST_READ_REQ : ST_DONE, acc, 7'(oper),
                                           1'b1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [2:0] st, logic [31:0] dw, logic [6:0] oa, logic [6:0] cnt,
                          logic flg, logic lst);
            machine_result_t e;
            n_results++;
            if (st == ST_PAGE)
                n_pages++;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected result, status %0d data %h", st, dw));
                return;
            end
            e = due_results.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (dw !== e.data_word)
                report($sformatf("data_word %h, expected %h", dw, e.data_word));
            if (oa !== e.oper_addr)
                report($sformatf("operand_address %0d, expected %0d", oa, e.oper_addr));
            if (cnt !== e.counter)
                report($sformatf("counter %0d, expected %0d", cnt, e.counter));
            if (flg !== e.flag)
                report($sformatf("compare_flag %b, expected %b", flg, e.flag));
            if (lst !== e.last)
                report($sformatf("last %b, expected %b", lst, e.last));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_NEW;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    machine_scoreboard sb = new();
    int items_sent;
    int idle_pct = 36;
    bit drained_once;

    decimal_word_machine_cpu_top #(
        .MEM_WORDS  (MEM_WORDS),
        .PAGE_WORDS (PAGE_WORDS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[6:0], s_tdata[38:7]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[31:0], m_tdata[38:32], m_tdata[45:39],
                                m_tdata[46], m_tlast);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [6:0] adr,
                             input logic [31:0] wd);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, wd, adr};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic write_word(input int adr, input logic [31:0] wd);
        send_item(ACT_WRITE, 7'(adr), wd);
    endtask

    task automatic step();
        send_item(ACT_STEP, 7'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] op_word(logic [7:0] a, logic [7:0] b, int n);
        return {a, b, CH_ZERO + 8'(n / 10), CH_ZERO + 8'(n % 10)};
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b >= CH_ZERO && b <= CH_NINE);
        return b;
    endfunction

    function automatic logic [31:0] random_instr();
        int r;
        int n;
        r = $urandom_range(99);
        n = $urandom_range(MEM_WORDS - 1);
        if (r < 16)
            return op_word(CH_L, CH_R, n);
        else if (r < 28)
            return op_word(CH_S, CH_R, n);
        else if (r < 42)
            return op_word(CH_C, CH_R, n);
        else if (r < 54)
            return op_word(CH_B, CH_T, $urandom_range(15));
        else if (r < 64)
            return op_word(CH_G, CH_D, n);
        else if (r < 76)
        begin
            if ($urandom_range(9) == 0)
                n = $urandom_range(MEM_WORDS - PAGE_WORDS + 1, MEM_WORDS - 1);
            else
                n = $urandom_range(MEM_WORDS - PAGE_WORDS);
            return op_word(CH_P, CH_D, n);
        end
        else if (r < 81)
            return {CH_H, 24'($urandom)};
        else if (r < 88)
        begin
            if ($urandom_range(1))
                return {CH_L, CH_R, non_digit(), CH_ZERO + 8'($urandom_range(9))};
            return {CH_G, CH_D, CH_ZERO + 8'($urandom_range(9)), non_digit()};
        end
        else
            return $urandom;
    endfunction

    // counter runs off the end, halt, bad operand character
    task automatic corner_jobs();
        send_item(ACT_NEW, '0, '0);
        write_word(0, op_word(CH_C, CH_R, 50));
        write_word(1, op_word(CH_B, CH_T, MEM_WORDS - 1));
        write_word(MEM_WORDS - 1, op_word(CH_L, CH_R, 0));
        repeat (4) step();
        send_item(ACT_NEW, '0, '0);
        write_word(0, {CH_H, 24'($urandom)});
        repeat (2) step();
        send_item(ACT_NEW, '0, '0);
        write_word(0, {CH_S, CH_R, non_digit(), CH_ZERO + 8'($urandom_range(9))});
        step();
    endtask

    task automatic program_job();
        int n;
        send_item(ACT_NEW, '0, '0);
        n = $urandom_range(4, 16);
        for (int i = 0; i < n; i++)
            write_word(i, random_instr());
        repeat ($urandom_range(6))
            write_word($urandom_range(20, MEM_WORDS - 1),
                       $urandom_range(1) ? $urandom : op_word(CH_L, CH_R, $urandom_range(99)));
        repeat ($urandom_range(4, 24))
        begin
            step();
            // host writes a random word at times, standing in for answers to read requests
            if ($urandom_range(4) == 0)
                write_word($urandom_range(MEM_WORDS - 1), $urandom);
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(3, 8))
            send_item(2'($urandom_range(3)), 7'($urandom_range(127)), $urandom);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        step();
        send_item(ACT_SPARE, 7'd127, 32'hFFFF_FFFF);
        send_item(ACT_NEW, '0, '0);
        write_word(90, 32'hFFFF_FFFF);
        write_word(99, 32'h0000_0000);
        send_item(ACT_WRITE, 7'd127, 32'h0000_0000);
        write_word(0, op_word(CH_L, CH_R, 90));
        write_word(1, op_word(CH_S, CH_R, 95));
        write_word(2, op_word(CH_C, CH_R, 95));
        write_word(3, op_word(CH_B, CH_T, 5));
        write_word(5, op_word(CH_G, CH_D, 42));
        write_word(6, op_word(CH_P, CH_D, 90));
        write_word(8, op_word(CH_P, CH_D, 91));
        repeat (8) step();

        corner_jobs();
        while (items_sent < 370)
        begin
            idle_pct = (items_sent >= 150 && items_sent < 250) ? 0 : 36;
            if (!drained_once && items_sent >= 300)
            begin
                wait_drained();
                drained_once = 1'b1;
            end
            case ($urandom_range(19))
                0:       corner_jobs();
                1, 2, 3: noise_burst();
                default: program_job();
            endcase
        end
        idle_pct = 36;

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("Covered %0d transactions, %0d steps, %0d results of which %0d page words.",
                 items_sent, sb.n_steps, sb.n_results, sb.n_pages);
        $display("Random idling on both sides, one stretch without idling, one full drain.");
        if (sb.errors == 0)
            $display("** decimal_word_machine_cpu_top: PASSED **");
        else
            $display("** decimal_word_machine_cpu_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout");
        $display("** decimal_word_machine_cpu_top: FAILED **");
        $finish;
    end

endmodule
